@@ sv/tts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

    localparam int MaxTasks    = 8;
    localparam int IdxW        = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
    localparam int CountW      = $clog2(MaxTasks + 1);
    localparam int ResultLimit = 8;
    localparam int RunIdxW     = $clog2(ResultLimit);
    localparam int RunCntW     = $clog2(ResultLimit + 1);

    localparam logic [1:0] ActAdd      = 2'd0;
    localparam logic [1:0] ActTick     = 2'd1;
    localparam logic [1:0] ActDispatch = 2'd2;
    localparam logic [1:0] ActDelete   = 2'd3;

    localparam logic [1:0] StatOk      = 2'd0;
    localparam logic [1:0] StatFull    = 2'd1;
    localparam logic [1:0] StatBadSlot = 2'd2;
    localparam logic [1:0] StatNone    = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  task_tag;
        logic [15:0] delay_ticks;
        logic [15:0] period_ticks;
        logic [2:0]  slot_index;
    } t_in_word;

    typedef struct packed {
        logic        run_valid;
        logic [7:0]  task_out;
        logic [1:0]  status;
        logic [3:0]  entry_count;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] delay;
        logic [15:0] period;
        logic [7:0]  pending;
    } t_entry;

    typedef struct packed {
        logic load;
        logic tick;
        logic shift;
        logic consume;
    } t_cell_cmd;

endpackage

`default_nettype wire

@@ sv/tts_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tts_cell (
    input  wire                 i_clk,
    input  tts_pkg::t_cell_cmd  i_cmd,
    input  tts_pkg::t_entry     i_load,
    input  tts_pkg::t_entry     i_next,
    output tts_pkg::t_entry     o_entry
);

    tts_pkg::t_entry r_entry;
    tts_pkg::t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.load) begin
            n_entry = i_load;
        end else if (i_cmd.shift) begin
            n_entry = i_next;
        end else if (i_cmd.consume) begin
            n_entry.pending = r_entry.pending - 8'd1;
        end else if (i_cmd.tick) begin
            if (r_entry.delay != 16'd0) begin
                n_entry.delay = r_entry.delay - 16'd1;
            end else begin
                n_entry.delay = r_entry.period;
                if (r_entry.pending != 8'hFF) begin
                    n_entry.pending = r_entry.pending + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

@@ sv/tick_task_scheduler_table.sv @@
// Time-triggered task table built as a row of entry cells.
// Input channel: i_in_valid / o_in_ready carry one command word (add, tick,
// dispatch, delete). Output channel: o_out_valid / i_out_ready carry result
// words; the final word of each command has last set.
// Add, tick and delete act on the cells in the accepting cycle (add loads the
// next free cell, tick steps the live entries, delete shifts the later ones
// down) and present their single result word on the next cycle.
// Dispatch walks the table one entry per cycle with a cursor; a one-shot
// entry that runs is removed by shifting every later cell down by one in
// that same cycle. The walk stops at the end of the table or after 8 runs,
// and the collected run words (at most 8) then drain one per cycle while
// the receiver keeps up.
// Only one command is in the block at a time; the next word is taken once
// the last result has left or is leaving the output register.
// Reset empties the table and the output register; entry contents are
// not cleared. A stalled receiver holds the output word and stops the
// drain and the input side alike.
`timescale 1ns / 1ps
`default_nettype none

module tick_task_scheduler_table (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  tts_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output tts_pkg::t_out_word  o_out_word
);

    localparam logic [1:0] StIdle  = 2'd0;
    localparam logic [1:0] StWalk  = 2'd1;
    localparam logic [1:0] StDrain = 2'd2;

    logic [1:0]                   r_state;
    logic [1:0]                   n_state;
    logic [tts_pkg::CountW-1:0]   r_count;
    logic [tts_pkg::CountW-1:0]   n_count;
    logic [tts_pkg::CountW-1:0]   r_idx;
    logic [tts_pkg::CountW-1:0]   n_idx;
    logic [tts_pkg::RunCntW-1:0]  r_n;
    logic [tts_pkg::RunCntW-1:0]  n_n;
    logic [tts_pkg::RunCntW-1:0]  r_rd;
    logic [tts_pkg::RunCntW-1:0]  n_rd;
    logic                         r_out_valid;
    logic                         n_out_valid;
    tts_pkg::t_out_word           r_out;
    tts_pkg::t_out_word           n_out;
    logic [7:0]                   r_runs [tts_pkg::ResultLimit];
    logic                         w_run_we;
    logic                         w_in_acc;
    logic                         w_last;
    tts_pkg::t_entry              w_sel;
    tts_pkg::t_entry              w_load;
    tts_pkg::t_entry              w_entry [tts_pkg::MaxTasks];
    tts_pkg::t_cell_cmd           w_cmd   [tts_pkg::MaxTasks];

    assign w_load.tag     = i_in_word.task_tag;
    assign w_load.delay   = i_in_word.delay_ticks;
    assign w_load.period  = i_in_word.period_ticks;
    assign w_load.pending = 8'd0;

    genvar g;
    generate
        for (g = 0; g < tts_pkg::MaxTasks; g++) begin : g_cell
            tts_pkg::t_entry w_next;
            if (g + 1 < tts_pkg::MaxTasks) begin : g_mid
                assign w_next = w_entry[g + 1];
            end else begin : g_end
                assign w_next = '0;
            end
            tts_cell u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd[g]),
                .i_load  (w_load),
                .i_next  (w_next),
                .o_entry (w_entry[g])
            );
        end
    endgenerate

    assign o_in_ready = (r_state == StIdle) && (!r_out_valid || i_out_ready);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_sel      = w_entry[r_idx[tts_pkg::IdxW-1:0]];
    assign w_last     = (r_n == '0) || (tts_pkg::RunCntW'(r_rd + 1'b1) == r_n);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_n         = r_n;
        n_rd        = r_rd;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_run_we    = 1'b0;
        for (int i = 0; i < tts_pkg::MaxTasks; i++) begin
            w_cmd[i] = '0;
        end
        case (r_state)
            StIdle: begin
                if (w_in_acc) begin
                    n_out.run_valid = 1'b0;
                    n_out.task_out  = 8'd0;
                    n_out.status    = tts_pkg::StatOk;
                    n_out.last      = 1'b1;
                    n_out_valid     = 1'b1;
                    case (i_in_word.action)
                        tts_pkg::ActAdd: begin
                            if (32'(r_count) < tts_pkg::MaxTasks) begin
                                for (int i = 0; i < tts_pkg::MaxTasks; i++) begin
                                    if (32'(i) == 32'(r_count)) begin
                                        w_cmd[i].load = 1'b1;
                                    end
                                end
                                n_count = r_count + 1'b1;
                            end else begin
                                n_out.status = tts_pkg::StatFull;
                            end
                        end
                        tts_pkg::ActTick: begin
                            for (int i = 0; i < tts_pkg::MaxTasks; i++) begin
                                if (32'(i) < 32'(r_count)) begin
                                    w_cmd[i].tick = 1'b1;
                                end
                            end
                        end
                        tts_pkg::ActDispatch: begin
                            n_out_valid = 1'b0;
                            n_state     = StWalk;
                            n_idx       = '0;
                            n_n         = '0;
                        end
                        default: begin
                            if (32'(i_in_word.slot_index) < 32'(r_count)) begin
                                for (int i = 0; i < tts_pkg::MaxTasks; i++) begin
                                    if (32'(i) >= 32'(i_in_word.slot_index)) begin
                                        w_cmd[i].shift = 1'b1;
                                    end
                                end
                                n_count = r_count - 1'b1;
                            end else begin
                                n_out.status = tts_pkg::StatBadSlot;
                            end
                        end
                    endcase
                    n_out.entry_count = 4'(n_count);
                end
            end
            StWalk: begin
                if ((r_idx < r_count) && (32'(r_n) < tts_pkg::ResultLimit)) begin
                    if (w_sel.pending != 8'd0) begin
                        w_run_we = 1'b1;
                        n_n      = r_n + 1'b1;
                        if (w_sel.period == 16'd0) begin
                            for (int i = 0; i < tts_pkg::MaxTasks; i++) begin
                                if (32'(i) >= 32'(r_idx)) begin
                                    w_cmd[i].shift = 1'b1;
                                end
                            end
                            n_count = r_count - 1'b1;
                        end else begin
                            for (int i = 0; i < tts_pkg::MaxTasks; i++) begin
                                if (32'(i) == 32'(r_idx)) begin
                                    w_cmd[i].consume = 1'b1;
                                end
                            end
                            n_idx = r_idx + 1'b1;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_state = StDrain;
                    n_rd    = '0;
                end
            end
            StDrain: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.run_valid   = (r_n != '0);
                    n_out.task_out    = (r_n != '0) ? r_runs[r_rd[tts_pkg::RunIdxW-1:0]]
                                                    : 8'd0;
                    n_out.status      = (r_n != '0) ? tts_pkg::StatOk : tts_pkg::StatNone;
                    n_out.entry_count = 4'(r_count);
                    n_out.last        = w_last;
                    n_rd              = r_rd + 1'b1;
                    if (w_last) begin
                        n_state = StIdle;
                    end
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_count     <= '0;
            r_idx       <= '0;
            r_n         <= '0;
            r_rd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_n         <= n_n;
            r_rd        <= n_rd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_run_we) begin
            r_runs[r_n[tts_pkg::RunIdxW-1:0]] <= w_sel.tag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= tts_pkg::MaxTasks)
        else $error("entry count exceeds table size");

    a_dispatch_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_word.action == tts_pkg::ActDispatch)) |=> (r_state == StWalk))
        else $error("dispatch did not start the walk");

    a_run_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.run_valid) |-> (o_out_word.status == tts_pkg::StatOk))
        else $error("run word with non-ok status");

    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == StDrain) && (n_state == StIdle)) |=> (o_out_valid && o_out_word.last))
        else $error("drain ended without a last word");

    a_run_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StWalk) |-> (32'(r_n) <= tts_pkg::ResultLimit))
        else $error("run buffer overflow");

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int LongHold   = 300;
    localparam int StallLimit = 4000;
    localparam int TailCycles = 40;

    class sched_scoreboard;
        tts_pkg::t_entry    slots[tts_pkg::MaxTasks];
        int unsigned        n_entries;
        tts_pkg::t_out_word expected[$];
        int unsigned        errors;
        int unsigned        words_seen;
        int unsigned        cmds_seen;
        int unsigned        runs;
        int unsigned        full_adds;
        int unsigned        bad_deletes;
        int unsigned        idle_dispatches;
        int unsigned        saturated;

        function new();
            n_entries = 0;
            errors = 0;
            words_seen = 0;
            cmds_seen = 0;
            runs = 0;
            full_adds = 0;
            bad_deletes = 0;
            idle_dispatches = 0;
            saturated = 0;
        endfunction

        function void drop_slot(int unsigned pos);
            for (int unsigned i = pos; i + 1 < n_entries; i++) begin
                slots[i] = slots[i + 1];
            end
            n_entries--;
        endfunction

        // Works out the result words of one accepted command word.
        function void note_input(tts_pkg::t_in_word w);
            tts_pkg::t_out_word res[$];
            tts_pkg::t_out_word r;
            int unsigned        i;
            cmds_seen++;
            r = '0;
            case (w.action)
                tts_pkg::ActAdd: begin
                    if (n_entries < tts_pkg::MaxTasks) begin
                        slots[n_entries].tag = w.task_tag;
                        slots[n_entries].delay = w.delay_ticks;
                        slots[n_entries].period = w.period_ticks;
                        slots[n_entries].pending = 8'd0;
                        n_entries++;
                    end else begin
                        r.status = tts_pkg::StatFull;
                        full_adds++;
                    end
                    res.push_back(r);
                end
                tts_pkg::ActTick: begin
                    for (i = 0; i < n_entries; i++) begin
                        if (slots[i].delay != 16'd0) begin
                            slots[i].delay = slots[i].delay - 16'd1;
                        end else begin
                            slots[i].delay = slots[i].period;
                            if (slots[i].pending != 8'hFF) begin
                                slots[i].pending = slots[i].pending + 8'd1;
                            end else begin
                                saturated++;
                            end
                        end
                    end
                    res.push_back(r);
                end
                tts_pkg::ActDispatch: begin
                    i = 0;
                    while (i < n_entries && res.size() < tts_pkg::ResultLimit) begin
                        if (slots[i].pending != 8'd0) begin
                            slots[i].pending = slots[i].pending - 8'd1;
                            r.run_valid = 1'b1;
                            r.task_out = slots[i].tag;
                            res.push_back(r);
                            runs++;
                            if (slots[i].period == 16'd0) begin
                                // The entry that slides into this slot is examined next.
                                drop_slot(i);
                                continue;
                            end
                        end
                        i++;
                    end
                    if (res.size() == 0) begin
                        r = '0;
                        r.status = tts_pkg::StatNone;
                        res.push_back(r);
                        idle_dispatches++;
                    end
                end
                default: begin
                    if (32'(w.slot_index) < n_entries) begin
                        drop_slot(32'(w.slot_index));
                    end else begin
                        r.status = tts_pkg::StatBadSlot;
                        bad_deletes++;
                    end
                    res.push_back(r);
                end
            endcase
            foreach (res[k]) begin
                res[k].entry_count = n_entries[3:0];
                res[k].last = (k == res.size() - 1);
                expected.push_back(res[k]);
            end
        endfunction

        task report(string what, logic [15:0] got_v, logic [15:0] want_v);
            errors++;
            if (errors <= 30) begin
                $display("Mismatch on %s in result word %0d: got %0h, expected %0h.",
                         what, words_seen, got_v, want_v);
            end
        endtask

        task check_result(tts_pkg::t_out_word got);
            tts_pkg::t_out_word want;
            words_seen++;
            if (expected.size() == 0) begin
                report("an unexpected word", 16'(got), 16'd0);
                return;
            end
            want = expected.pop_front();
            if (got.run_valid !== want.run_valid)
                report("run_valid", 16'(got.run_valid), 16'(want.run_valid));
            if (got.task_out !== want.task_out)
                report("task_out", 16'(got.task_out), 16'(want.task_out));
            if (got.status !== want.status)
                report("status", 16'(got.status), 16'(want.status));
            if (got.entry_count !== want.entry_count)
                report("entry_count", 16'(got.entry_count), 16'(want.entry_count));
            if (got.last !== want.last)
                report("last", 16'(got.last), 16'(want.last));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    tts_pkg::t_in_word  in_word = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    tts_pkg::t_out_word out_word;

    int snd_idle_pct = 25;
    int rcv_idle_pct = 80;
    int hold_req = 0;
    int hold_done = 0;
    int quiet_cycles = 0;

    sched_scoreboard sb = new();

    tick_task_scheduler_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic tts_pkg::t_in_word make_word(logic [1:0] action, logic [7:0] tag,
                                                    logic [15:0] delay, logic [15:0] period,
                                                    logic [2:0] slot);
        tts_pkg::t_in_word w;
        w.action = action;
        w.task_tag = tag;
        w.delay_ticks = delay;
        w.period_ticks = period;
        w.slot_index = slot;
        return w;
    endfunction

    function automatic tts_pkg::t_in_word random_command();
        tts_pkg::t_in_word w;
        int                pick;
        w = make_word(tts_pkg::ActTick, 8'($urandom), 16'($urandom), 16'($urandom),
                      3'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            w.action = tts_pkg::ActAdd;
            if ($urandom_range(0, 4) != 0) w.delay_ticks = 16'($urandom_range(0, 3));
            pick = $urandom_range(0, 9);
            if (pick < 4) w.period_ticks = 16'd0;
            else if (pick < 8) w.period_ticks = 16'($urandom_range(1, 4));
        end else if (pick < 63) begin
            w.action = tts_pkg::ActTick;
        end else if (pick < 85) begin
            w.action = tts_pkg::ActDispatch;
        end else begin
            w.action = tts_pkg::ActDelete;
        end
        return w;
    endfunction

    function automatic tts_pkg::t_in_word junk_word(logic [1:0] action);
        return make_word(action, 8'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
    endfunction

    task automatic send_word(tts_pkg::t_in_word w);
        while ($urandom_range(1, 100) <= snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (!in_ready);
        sb.note_input(w);
    endtask

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_left == 0 && hold_done != hold_req) begin
                hold_done = hold_req;
                hold_left = LongHold;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(1, 100) > rcv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_result(out_word);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("No word moved for %0d cycles.", StallLimit);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_word(make_word(tts_pkg::ActDispatch, 8'h00, 16'h0000, 16'h0000, 3'd0));
        send_word(make_word(tts_pkg::ActDelete, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd0));
        send_word(make_word(tts_pkg::ActAdd, 8'h00, 16'h0000, 16'h0000, 3'd7));
        send_word(make_word(tts_pkg::ActAdd, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd0));
        send_word(make_word(tts_pkg::ActAdd, 8'hA5, 16'h0001, 16'h0002, 3'd0));
        send_word(make_word(tts_pkg::ActTick, 8'h00, 16'h0000, 16'h0000, 3'd0));
        send_word(make_word(tts_pkg::ActTick, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7));
        send_word(make_word(tts_pkg::ActDispatch, 8'h00, 16'h0000, 16'h0000, 3'd0));
        for (int k = 0; k < 6; k++) begin
            send_word(make_word(tts_pkg::ActAdd, 8'(8'h10 + k), 16'h0000, 16'h0000, 3'd0));
        end
        send_word(make_word(tts_pkg::ActAdd, 8'h5A, 16'h0003, 16'h0001, 3'd0));
        send_word(make_word(tts_pkg::ActTick, 8'h00, 16'h0000, 16'h0000, 3'd0));
        send_word(make_word(tts_pkg::ActTick, 8'h00, 16'h0000, 16'h0000, 3'd0));
        send_word(make_word(tts_pkg::ActDispatch, 8'h00, 16'h0000, 16'h0000, 3'd0));
        send_word(make_word(tts_pkg::ActDispatch, 8'h00, 16'h0000, 16'h0000, 3'd0));
        send_word(make_word(tts_pkg::ActDelete, 8'h00, 16'h0000, 16'h0000, 3'd7));
        send_word(make_word(tts_pkg::ActDelete, 8'h00, 16'h0000, 16'h0000, 3'd0));
        send_word(make_word(tts_pkg::ActDelete, 8'h00, 16'h0000, 16'h0000, 3'd1));

        for (int k = 0; k < 70; k++) send_word(random_command());
        snd_idle_pct = 80;
        rcv_idle_pct = 25;
        for (int k = 0; k < 70; k++) send_word(random_command());
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req++;
        for (int k = 0; k < 70; k++) send_word(random_command());

        // Saturate a one-shot entry's run count; a single dispatch still removes it.
        for (int k = 0; k < tts_pkg::MaxTasks; k++) begin
            send_word(make_word(tts_pkg::ActDelete, 8'h00, 16'h0000, 16'h0000, 3'd0));
        end
        send_word(make_word(tts_pkg::ActAdd, 8'h3C, 16'h0000, 16'h0000, 3'd0));
        for (int k = 0; k < 258; k++) begin
            send_word(junk_word(tts_pkg::ActTick));
        end
        for (int k = 0; k < 2; k++) begin
            send_word(junk_word(tts_pkg::ActDispatch));
        end
        in_valid <= 1'b0;

        while (sb.expected.size() != 0) @(posedge clk);
        repeat (TailCycles) @(posedge clk);

        $display("Checked %0d result words from %0d commands.", sb.words_seen, sb.cmds_seen);
        $display("Runs %0d, saturated ticks %0d, full adds %0d, bad deletes %0d, empty %0d.",
                 sb.runs, sb.saturated, sb.full_adds, sb.bad_deletes, sb.idle_dispatches);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
